[rtl/core/adbkbd_pkg.sv]
// Shared types, codes and constants of the desktop bus keyboard device.
package adbkbd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned REPLY_MAX       = 6;
  localparam int unsigned REPLY_LEN_W     = 3;

  localparam logic [7:0] ADDR_FLAGS_RST   = 8'h62;
  localparam logic [7:0] HANDLER_RST      = 8'h05;
  localparam logic [7:0] LED_RST          = 8'hff;
  localparam logic [7:0] LISTEN_ADDR_ONLY = 8'hfe;
  localparam logic [7:0] LISTEN_FULL      = 8'h00;
  localparam logic [7:0] FLAGS_KEEP_MASK  = 8'hd0;
  localparam logic [7:0] FLAGS_TAKE_MASK  = 8'h2f;
  localparam logic [7:0] LED_FILL         = 8'hf8;
  localparam logic [7:0] NO_KEY           = 8'hff;
  localparam logic [7:0] CLOCK_BYTE_A     = 8'h01;
  localparam logic [7:0] CLOCK_BYTE_B     = 8'h07;
  localparam logic [7:0] CLOCK_BYTE_C     = 8'h0c;

  typedef enum logic [1:0] {
    MODE_KEY_DOWN = 2'd0,
    MODE_KEY_UP   = 2'd1,
    MODE_BUS_CMD  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    BC_RESET_FLUSH = 2'd0,
    BC_RESERVED    = 2'd1,
    BC_LISTEN      = 2'd2,
    BC_TALK        = 2'd3
  } bus_cmd_e;

  typedef enum logic [1:0] {
    BREG_0 = 2'd0,
    BREG_1 = 2'd1,
    BREG_2 = 2'd2,
    BREG_3 = 2'd3
  } bus_reg_e;

  typedef enum logic [1:0] {
    QOP_APPEND = 2'd0,
    QOP_REMOVE = 2'd1,
    QOP_POP    = 2'd2,
    QOP_CLEAR  = 2'd3
  } q_op_e;

  typedef enum logic [1:0] {
    QS_IDLE,
    QS_SEARCH,
    QS_POP,
    QS_SHIFT
  } q_state_e;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_POP_FIRST,
    KS_POP_SECOND,
    KS_LOAD
  } kbd_state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_REPLY,
    ACT_POP
  } act_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] key_code;
    logic [7:0] command_byte;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [7:0] modifier_bits;
    logic [3:0] random_nibble;
  } kbd_req_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
  } kbd_rsp_t;

  typedef struct packed {
    logic       valid;
    q_op_e      op;
    logic [6:0] code;
  } q_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       pop_valid;
    logic [6:0] pop_data;
  } q_stat_t;

  typedef logic [REPLY_MAX-1:0][7:0] reply_buf_t;

  typedef struct packed {
    logic                   valid;
    logic [REPLY_LEN_W-1:0] len;
    reply_buf_t             bytes;
  } emit_load_t;

endpackage

[rtl/core/desktop_bus_keyboard_device.sv]
// Top level of the desktop bus keyboard device: decode, device registers and control.
// A key-down is appended to the queue directly; a key-up searches the queue and then shifts
// the later entries down, one queue entry at a time, through the key memory.
// A talk register 0 request pops up to two keys from the queue, then the reply run leaves at
// one byte per cycle while the output does not stall; other bus requests load their reply directly.
// One request is handled at a time: a new one waits for the control and any queue walk to finish.
// Reset clears the queue count and restores address 0x62, handler 0x05 and LEDs 0xff.
module desktop_bus_keyboard_device #(
  parameter int unsigned QueueDepth = adbkbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  adbkbd_pkg::kbd_req_t in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output adbkbd_pkg::kbd_rsp_t out_rsp_o
);
  import adbkbd_pkg::*;

  // Control state and the device registers seen on the bus.
  kbd_state_e             state_q, state_d;
  logic [7:0]             addr_flags_q, addr_flags_d;
  logic [7:0]             handler_q, handler_d;
  logic [7:0]             led_q, led_d;
  reply_buf_t             rep_q, rep_d;
  logic [REPLY_LEN_W-1:0] rep_len_q, rep_len_d;

  q_cmd_t     q_cmd;
  q_stat_t    q_stat;
  emit_load_t e_load;
  logic       e_ready;

  logic       accept;
  act_e       act;
  logic [3:0] bus_adr;
  bus_cmd_e   bus_cmd;
  bus_reg_e   bus_reg;
  logic       clock_byte;
  logic [7:0] mod_hi;
  logic [7:0] mod_lo;
  logic [7:0] popped;

  // A new request is taken only when both the control and the queue walk are idle.
  assign in_stall_o = (state_q != KS_IDLE) || q_stat.busy;
  assign accept     = in_valid_i && !in_stall_o;

  assign bus_adr    = in_req_i.command_byte[7:4];
  assign bus_cmd    = bus_cmd_e'(in_req_i.command_byte[3:2]);
  assign bus_reg    = bus_reg_e'(in_req_i.command_byte[1:0]);
  assign clock_byte = (in_req_i.command_byte == CLOCK_BYTE_A) ||
                      (in_req_i.command_byte == CLOCK_BYTE_B) ||
                      (in_req_i.command_byte == CLOCK_BYTE_C);

  // Modifier reply: a held flag pulls its bit low, the low three LED bits fill the low byte.
  always_comb begin
    mod_hi = 8'hff;
    mod_lo = led_q | LED_FILL;
    mod_lo[6] = mod_lo[6] & ~in_req_i.modifier_bits[0];
    mod_lo[7] = mod_lo[7] & ~in_req_i.modifier_bits[1];
    mod_hi[0] = ~in_req_i.modifier_bits[2];
    mod_hi[1] = ~in_req_i.modifier_bits[3];
    mod_hi[2] = ~in_req_i.modifier_bits[4];
    mod_hi[3] = ~in_req_i.modifier_bits[5];
    mod_hi[5] = ~in_req_i.modifier_bits[6];
    mod_hi[6] = ~in_req_i.modifier_bits[7];
  end

  // A key that left the queue, or the filler byte when the queue ran dry.
  assign popped = q_stat.pop_valid ? {1'b0, q_stat.pop_data} : NO_KEY;

  // Decode of an accepted request: register updates, queue work and reply contents.
  always_comb begin
    act          = ACT_NONE;
    addr_flags_d = addr_flags_q;
    handler_d    = handler_q;
    led_d        = led_q;
    rep_d        = rep_q;
    rep_len_d    = rep_len_q;
    q_cmd.valid  = 1'b0;
    q_cmd.op     = QOP_APPEND;
    q_cmd.code   = in_req_i.key_code;
    if (state_q == KS_IDLE && accept) begin
      unique case (in_req_i.mode)
        MODE_KEY_DOWN: begin
          q_cmd.valid = 1'b1;
          q_cmd.op    = QOP_APPEND;
        end
        MODE_KEY_UP: begin
          q_cmd.valid = 1'b1;
          q_cmd.op    = QOP_REMOVE;
        end
        MODE_BUS_CMD: begin
          priority if (bus_cmd == BC_RESET_FLUSH && bus_reg == BREG_0) begin
            // SendReset acts at any address, restores every default and clears the queue.
            addr_flags_d = ADDR_FLAGS_RST;
            handler_d    = HANDLER_RST;
            led_d        = LED_RST;
            q_cmd.valid  = 1'b1;
            q_cmd.op     = QOP_CLEAR;
          end else if (clock_byte) begin
            // Bytes meant for the clock chip are not ours.
          end else if (bus_adr != addr_flags_q[3:0]) begin
            // Another device is addressed.
          end else if (bus_cmd == BC_LISTEN) begin
            if (bus_reg == BREG_2) begin
              led_d = in_req_i.data_second;
            end else if (bus_reg == BREG_3) begin
              if (in_req_i.data_second == LISTEN_ADDR_ONLY) begin
                addr_flags_d = {addr_flags_q[7:4], in_req_i.data_first[3:0]};
              end else if (in_req_i.data_second == LISTEN_FULL) begin
                addr_flags_d = (addr_flags_q & FLAGS_KEEP_MASK) |
                               (in_req_i.data_first & FLAGS_TAKE_MASK);
              end
            end
          end else if (bus_cmd == BC_RESET_FLUSH && bus_reg == BREG_1) begin
            q_cmd.valid = 1'b1;
            q_cmd.op    = QOP_CLEAR;
            act         = ACT_REPLY;
            rep_d[0]    = 8'd1;
            rep_len_d   = REPLY_LEN_W'(1);
          end else if (bus_cmd != BC_TALK) begin
            act       = ACT_REPLY;
            rep_d[0]  = 8'd1;
            rep_len_d = REPLY_LEN_W'(1);
          end else begin
            unique case (bus_reg)
              BREG_0: begin
                q_cmd.valid = 1'b1;
                q_cmd.op    = QOP_POP;
                act         = ACT_POP;
                rep_d[0]    = 8'd1;
                rep_d[3]    = 8'd0;
                rep_d[4]    = 8'd1;
                rep_len_d   = REPLY_LEN_W'(5);
              end
              BREG_1: begin
                act       = ACT_REPLY;
                rep_d[0]  = 8'd1;
                rep_d[1]  = 8'd0;
                rep_d[2]  = 8'd1;
                rep_len_d = REPLY_LEN_W'(3);
              end
              BREG_2: begin
                act       = ACT_REPLY;
                rep_d[0]  = 8'd1;
                rep_d[1]  = mod_hi;
                rep_d[2]  = mod_lo;
                rep_d[3]  = 8'd0;
                rep_d[4]  = 8'd1;
                rep_len_d = REPLY_LEN_W'(5);
              end
              BREG_3: begin
                act       = ACT_REPLY;
                rep_d[0]  = 8'd1;
                rep_d[1]  = 8'd1;
                rep_d[2]  = {addr_flags_q[7:4], in_req_i.random_nibble};
                rep_d[3]  = handler_q;
                rep_d[4]  = 8'd0;
                rep_d[5]  = 8'd1;
                rep_len_d = REPLY_LEN_W'(6);
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end else if (state_q == KS_POP_FIRST && !q_stat.busy) begin
      rep_d[1] = popped;
      if (q_stat.pop_valid) begin
        // A real key came out, so a second one may follow it.
        q_cmd.valid = 1'b1;
        q_cmd.op    = QOP_POP;
      end else begin
        rep_d[2] = NO_KEY;
      end
    end else if (state_q == KS_POP_SECOND && !q_stat.busy) begin
      rep_d[2] = popped;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KS_IDLE: begin
        if (act == ACT_POP) begin
          state_d = KS_POP_FIRST;
        end else if (act == ACT_REPLY) begin
          state_d = KS_LOAD;
        end
      end
      KS_POP_FIRST: begin
        if (!q_stat.busy) begin
          state_d = q_stat.pop_valid ? KS_POP_SECOND : KS_LOAD;
        end
      end
      KS_POP_SECOND: begin
        if (!q_stat.busy) begin
          state_d = KS_LOAD;
        end
      end
      KS_LOAD: begin
        if (e_ready) begin
          state_d = KS_IDLE;
        end
      end
      default: state_d = KS_IDLE;
    endcase
  end

  // Outputs: the reply run moves to the output buffer once it has drained.
  always_comb begin
    e_load.valid = (state_q == KS_LOAD) && e_ready;
    e_load.len   = rep_len_q;
    e_load.bytes = rep_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= KS_IDLE;
      addr_flags_q <= ADDR_FLAGS_RST;
      handler_q    <= HANDLER_RST;
      led_q        <= LED_RST;
    end else begin
      state_q      <= state_d;
      addr_flags_q <= addr_flags_d;
      handler_q    <= handler_d;
      led_q        <= led_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q     <= rep_d;
    rep_len_q <= rep_len_d;
  end

  adbkbd_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .stat_o (q_stat)
  );

  adbkbd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (e_load),
    .ready_o     (e_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_queue_idle_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cmd.valid |-> !q_stat.busy)
    else $error("queue request issued during a queue walk");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_load.valid |-> !out_valid_o)
    else $error("reply loaded over a run still in flight");

  a_second_pop_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == KS_POP_SECOND) |-> rep_q[1][7] == 1'b0)
    else $error("second pop without a first key");

  a_load_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == KS_LOAD) |-> (rep_len_q == REPLY_LEN_W'(1) || rep_len_q == REPLY_LEN_W'(3) ||
                              rep_len_q == REPLY_LEN_W'(5) || rep_len_q == REPLY_LEN_W'(6)))
    else $error("reply run of impossible length");

endmodule

[rtl/core/adbkbd_queue.sv]
// Key queue: synchronous memory with append, first-match removal, pop and clear.
module adbkbd_queue #(
  parameter int unsigned QueueDepth = adbkbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  adbkbd_pkg::q_cmd_t  cmd_i,
  output adbkbd_pkg::q_stat_t stat_o
);
  import adbkbd_pkg::*;

  localparam int unsigned IW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  logic [6:0]    mem_q [QueueDepth];
  logic [6:0]    rdata_q;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [6:0]    wdata;
  logic          we;

  q_state_e      state_q, state_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [6:0]    code_q, code_d;
  logic          pop_valid_q, pop_valid_d;
  logic [6:0]    pop_data_q, pop_data_d;

  logic [CW:0]   ptr_n1;
  logic [CW:0]   ptr_n2;
  logic [CW:0]   count_x;
  logic          found;
  logic          search_end;
  logic          shift_end;

  assign ptr_n1     = (CW+1)'(ptr_q) + (CW+1)'(1);
  assign ptr_n2     = (CW+1)'(ptr_q) + (CW+1)'(2);
  assign count_x    = (CW+1)'(count_q);
  assign found      = (rdata_q == code_q);
  assign search_end = (ptr_n1 >= count_x);
  assign shift_end  = (ptr_n2 >= count_x);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      QS_IDLE: begin
        if (cmd_i.valid && count_q != '0) begin
          if (cmd_i.op == QOP_REMOVE) begin
            state_d = QS_SEARCH;
          end else if (cmd_i.op == QOP_POP) begin
            state_d = QS_POP;
          end
        end
      end
      QS_SEARCH: begin
        if (found) begin
          state_d = search_end ? QS_IDLE : QS_SHIFT;
        end else if (search_end) begin
          state_d = QS_IDLE;
        end
      end
      QS_POP: begin
        state_d = search_end ? QS_IDLE : QS_SHIFT;
      end
      QS_SHIFT: begin
        if (shift_end) begin
          state_d = QS_IDLE;
        end
      end
      default: state_d = QS_IDLE;
    endcase
  end

  always_comb begin
    ptr_d       = ptr_q;
    count_d     = count_q;
    code_d      = code_q;
    pop_valid_d = pop_valid_q;
    pop_data_d  = pop_data_q;
    raddr       = ptr_n1[IW-1:0];
    we          = 1'b0;
    waddr       = ptr_q;
    wdata       = rdata_q;
    unique case (state_q)
      QS_IDLE: begin
        if (cmd_i.valid) begin
          unique case (cmd_i.op)
            QOP_APPEND: begin
              if (count_q < CW'(QueueDepth)) begin
                we      = 1'b1;
                waddr   = count_q[IW-1:0];
                wdata   = cmd_i.code;
                count_d = count_q + 1'b1;
              end
            end
            QOP_REMOVE: begin
              code_d = cmd_i.code;
              ptr_d  = '0;
              raddr  = '0;
            end
            QOP_POP: begin
              ptr_d       = '0;
              raddr       = '0;
              pop_valid_d = (count_q != '0);
            end
            QOP_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      QS_SEARCH: begin
        if (found) begin
          // The entry after the hit is already being read for the shift.
          if (search_end) begin
            count_d = count_q - 1'b1;
          end
        end else if (!search_end) begin
          ptr_d = ptr_n1[IW-1:0];
          raddr = ptr_n1[IW-1:0];
        end
      end
      QS_POP: begin
        pop_data_d = rdata_q;
        if (search_end) begin
          count_d = count_q - 1'b1;
        end
      end
      QS_SHIFT: begin
        we = 1'b1;
        if (shift_end) begin
          count_d = count_q - 1'b1;
        end else begin
          ptr_d = ptr_n1[IW-1:0];
          raddr = ptr_n2[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= QS_IDLE;
      count_q     <= '0;
      pop_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pop_valid_q <= pop_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    code_q     <= code_d;
    pop_data_q <= pop_data_d;
  end

  assign stat_o.busy      = (state_q != QS_IDLE);
  assign stat_o.pop_valid = pop_valid_q;
  assign stat_o.pop_data  = pop_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QueueDepth))
    else $error("queue count exceeds depth");

  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == QS_SEARCH || state_q == QS_SHIFT || state_q == QS_POP) |-> count_q != '0)
    else $error("queue walk on an empty queue");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == QS_IDLE && cmd_i.valid && cmd_i.op == QOP_APPEND &&
     count_q < CW'(QueueDepth)) |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the queue");

endmodule

[rtl/core/adbkbd_emit.sv]
// Reply buffer that hands out a loaded byte run one byte per request.
module adbkbd_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  adbkbd_pkg::emit_load_t load_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output adbkbd_pkg::kbd_rsp_t   out_rsp_o
);
  import adbkbd_pkg::*;

  reply_buf_t             buf_q, buf_d;
  logic [REPLY_LEN_W-1:0] rem_q, rem_d;
  logic                   take;

  assign take = out_valid_o && !out_stall_i;

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (load_i.valid) begin
      buf_d = load_i.bytes;
      rem_d = load_i.len;
    end else if (take) begin
      buf_d = buf_q >> 8;
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign ready_o               = (rem_q == '0);
  assign out_valid_o           = (rem_q != '0);
  assign out_rsp_o.reply_byte  = buf_q[0];
  assign out_rsp_o.reply_last  = (rem_q == REPLY_LEN_W'(1));

endmodule
